/* hdl/vpa_pkg.sv */
// shared types and constants of the variable partition allocator
package vpa_pkg;

  localparam int SIZE_BITS        = 16;
  localparam int OWNER_BITS       = 8;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int CNT_OUT_BITS     = 6;

  localparam logic [SIZE_BITS-1:0] RESET_TOTAL = SIZE_BITS'(1024);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_REPORT  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NONE  = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_TOTAL_SIZE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_DEC,
    S_SHUP,
    S_SPLIT_LO,
    S_SPLIT_HI,
    S_DEAL_DEC,
    S_RD_NEXT,
    S_RD_PREV,
    S_MERGE,
    S_SHDN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [OWNER_BITS-1:0] owner_id;
    logic [SIZE_BITS-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [SIZE_BITS-1:0]    free_total;
    logic [CNT_OUT_BITS-1:0] free_count;
    logic [SIZE_BITS-1:0]    largest_free;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  size;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } seg_t;

endpackage

/* hdl/vpa_mem.sv */
// segment table memory, one write and one registered read per cycle
module vpa_mem import vpa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int AW           = $clog2(MAX_SEGMENTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  seg_t          wdata,
  input  logic [AW-1:0] raddr,
  output seg_t          rdata
);

  seg_t mem [MAX_SEGMENTS];
  seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/vpa_ctrl.sv */
// sequencer with the shared compare and add unit that walks the segment table
module vpa_ctrl import vpa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int AW           = $clog2(MAX_SEGMENTS),
  parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_wdata,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output seg_t                 mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  seg_t                 mem_rdata
);

  state_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  policy_t policy_r, policy_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic dv_r, dv_nxt;
  logic [AW-1:0] di_r, di_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] pick_size_r, pick_size_nxt;
  logic pick_free_r, pick_free_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  status_t status_r, status_nxt;
  logic init_r, init_nxt;
  logic nf_r, nf_nxt;
  logic pf_r, pf_nxt;
  logic [1:0] delta_r, delta_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic accept;
  logic issue_up, issue_fw, scan_stop, scan_end, fits, better;
  logic size_lt, size_gt, size_ge_req;
  logic [SIZE_BITS-1:0] sum;
  logic next_ok, prev_ok;

  assign busy   = (state_r != S_IDLE) || init_r;
  assign accept = start && !busy;

  // shared unit: one adder and the size compares
  assign sum         = acc_r + mem_rdata.size;
  assign size_lt     = mem_rdata.size < pick_size_r;
  assign size_gt     = mem_rdata.size > pick_size_r;
  assign size_ge_req = mem_rdata.size >= req_r;

  assign issue_fw = rd_r < cnt_r;
  assign issue_up = rd_r > CW'(pick_r);
  assign fits     = mem_rdata.free && size_ge_req;
  assign next_ok  = (CW'(pick_r) + CW'(1)) < cnt_r;
  assign prev_ok  = pick_r != '0;

  always_comb begin
    better = 1'b0;
    unique case (policy_r)
      POL_FIRST: better = fits && !found_r;
      POL_BEST:  better = fits && (!found_r || size_lt);
      POL_WORST: better = fits && (!found_r || size_gt);
      POL_NONE:  better = 1'b0;
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    scan_stop = 1'b0;
    if (dv_r) begin
      if (cmd_r == CMD_ALLOC) begin
        scan_stop = fits && (policy_r == POL_FIRST);
      end else if (cmd_r == CMD_DEALLOC) begin
        scan_stop = mem_rdata.owner == owner_r;
      end
    end
    scan_end = scan_stop || (!issue_fw && !dv_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_NONE) begin
            state_nxt = S_DONE;
          end else if (in_item.cmd == CMD_ALLOC &&
                       (in_item.owner_id == '0 || in_item.request_size == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          priority if (cmd_r == CMD_ALLOC) state_nxt = S_ALLOC_DEC;
          else if (cmd_r == CMD_DEALLOC)  state_nxt = S_DEAL_DEC;
          else                            state_nxt = S_DONE;
        end
      end
      S_ALLOC_DEC: begin
        priority if (!found_r)                     state_nxt = S_DONE;
        else if (pick_size_r == req_r)             state_nxt = S_SPLIT_HI;
        else if (cnt_r == CW'(MAX_SEGMENTS))       state_nxt = S_DONE;
        else                                       state_nxt = S_SHUP;
      end
      S_SHUP:     if (!issue_up && !dv_r) state_nxt = S_SPLIT_LO;
      S_SPLIT_LO: state_nxt = S_SPLIT_HI;
      S_SPLIT_HI: state_nxt = S_DONE;
      S_DEAL_DEC: begin
        if (!found_r || pick_free_r) state_nxt = S_DONE;
        else                         state_nxt = S_RD_NEXT;
      end
      S_RD_NEXT: state_nxt = S_RD_PREV;
      S_RD_PREV: state_nxt = S_MERGE;
      S_MERGE:   state_nxt = (nf_r || pf_r) ? S_SHDN : S_DONE;
      S_SHDN:    if (!issue_fw && !dv_r) state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    cmd_nxt       = cmd_r;
    policy_nxt    = policy_r;
    owner_nxt     = owner_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    dv_nxt        = 1'b0;
    di_nxt        = di_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_size_nxt = pick_size_r;
    pick_free_nxt = pick_free_r;
    acc_nxt       = acc_r;
    fcnt_nxt      = fcnt_r;
    status_nxt    = status_r;
    init_nxt      = init_r;
    nf_nxt        = nf_r;
    pf_nxt        = pf_r;
    delta_nxt     = delta_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = rd_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we && cfg_index == CFG_FIT_POLICY) begin
          policy_nxt = policy_t'(cfg_wdata[1:0]);
        end
        if (cfg_we && cfg_index == CFG_TOTAL_SIZE) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: cfg_wdata, free: 1'b1, owner: '0};
          cnt_nxt   = CW'(1);
          init_nxt  = 1'b0;
        end else if (init_r) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: RESET_TOTAL, free: 1'b1, owner: '0};
          cnt_nxt   = CW'(1);
          init_nxt  = 1'b0;
        end
        if (accept) begin
          cmd_nxt       = cmd_t'(in_item.cmd);
          owner_nxt     = in_item.owner_id;
          req_nxt       = in_item.request_size;
          rd_nxt        = '0;
          found_nxt     = 1'b0;
          pick_size_nxt = '0;
          acc_nxt       = '0;
          fcnt_nxt      = '0;
          status_nxt    = (in_item.cmd == CMD_ALLOC) ? ST_NO_SPACE : ST_OK;
        end
      end
      S_SCAN: begin
        if (dv_r) begin
          unique case (cmd_r)
            CMD_ALLOC: begin
              if (better) begin
                found_nxt     = 1'b1;
                pick_nxt      = di_r;
                pick_size_nxt = mem_rdata.size;
              end
            end
            CMD_DEALLOC: begin
              if (scan_stop) begin
                found_nxt     = 1'b1;
                pick_nxt      = di_r;
                pick_size_nxt = mem_rdata.size;
                pick_free_nxt = mem_rdata.free;
              end
            end
            CMD_REPORT: begin
              if (mem_rdata.free) begin
                acc_nxt  = sum;
                fcnt_nxt = fcnt_r + CW'(1);
                if (size_gt) pick_size_nxt = mem_rdata.size;
              end
            end
            default: ;
          endcase
        end
        if (issue_fw && !scan_stop) begin
          dv_nxt = 1'b1;
          di_nxt = rd_r[AW-1:0];
          rd_nxt = rd_r + CW'(1);
        end
      end
      S_ALLOC_DEC: begin
        if (!found_r) begin
          status_nxt = ST_NO_SPACE;
        end else if (pick_size_r != req_r && cnt_r == CW'(MAX_SEGMENTS)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
        end
        rd_nxt = cnt_r - CW'(1);
      end
      S_SHUP: begin
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = di_r + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (issue_up) begin
          dv_nxt = 1'b1;
          di_nxt = rd_r[AW-1:0];
          rd_nxt = rd_r - CW'(1);
        end
      end
      S_SPLIT_LO: begin
        mem_we    = 1'b1;
        mem_waddr = pick_r + AW'(1);
        mem_wdata = '{size: pick_size_r - req_r, free: 1'b1, owner: '0};
        cnt_nxt   = cnt_r + CW'(1);
      end
      S_SPLIT_HI: begin
        mem_we    = 1'b1;
        mem_waddr = pick_r;
        mem_wdata = '{size: req_r, free: 1'b0, owner: owner_r};
      end
      S_DEAL_DEC: begin
        priority if (!found_r) status_nxt = ST_NOT_FOUND;
        else if (pick_free_r)  status_nxt = ST_ALREADY_FREE;
        else                   status_nxt = ST_OK;
        acc_nxt   = pick_size_r;
        nf_nxt    = 1'b0;
        pf_nxt    = 1'b0;
        mem_raddr = pick_r + AW'(1);
      end
      S_RD_NEXT: begin
        mem_raddr = pick_r - AW'(1);
        if (next_ok && mem_rdata.free) begin
          nf_nxt  = 1'b1;
          acc_nxt = sum;
        end
      end
      S_RD_PREV: begin
        if (prev_ok && mem_rdata.free) begin
          pf_nxt  = 1'b1;
          acc_nxt = sum;
        end
      end
      S_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = pf_r ? (pick_r - AW'(1)) : pick_r;
        mem_wdata = '{size: acc_r, free: 1'b1, owner: '0};
        delta_nxt = {1'b0, nf_r} + {1'b0, pf_r};
        rd_nxt    = CW'(pick_r) + CW'(1) + CW'(nf_r);
      end
      S_SHDN: begin
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = di_r - AW'(delta_r);
          mem_wdata = mem_rdata;
        end
        if (issue_fw) begin
          dv_nxt = 1'b1;
          di_nxt = rd_r[AW-1:0];
          rd_nxt = rd_r + CW'(1);
        end else if (!dv_r) begin
          cnt_nxt = cnt_r - CW'(delta_r);
        end
      end
      S_DONE: begin
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = status_r;
        if (cmd_r == CMD_REPORT) begin
          out_item_nxt.free_total   = acc_r;
          out_item_nxt.free_count   = fcnt_r[CNT_OUT_BITS-1:0];
          out_item_nxt.largest_free = pick_size_r;
        end else begin
          out_item_nxt.free_total   = '0;
          out_item_nxt.free_count   = '0;
          out_item_nxt.largest_free = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIRST;
      cnt_r       <= CW'(1);
      init_r      <= 1'b1;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      cnt_r       <= cnt_nxt;
      init_r      <= init_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    owner_r     <= owner_nxt;
    req_r       <= req_nxt;
    rd_r        <= rd_nxt;
    di_r        <= di_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    pick_size_r <= pick_size_nxt;
    pick_free_r <= pick_free_nxt;
    acc_r       <= acc_nxt;
    fcnt_r      <= fcnt_nxt;
    status_r    <= status_nxt;
    nf_r        <= nf_nxt;
    pf_r        <= pf_nxt;
    delta_r     <= delta_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/variable_partition_allocator_core.sv */
// top level of the first / best / worst fit segment allocator
// A command is taken when start is high and busy is low; its single result
// appears on out_item for one cycle with out_valid and cannot be held off.
// Every command but a no-op or a rejected allocate walks the segment table
// through one memory read port, one entry per cycle. A report scans the whole
// table; an allocate may scan it in full and then shift entries up for a split.
// A deallocate's scan stops at the owner, two neighbor reads follow, and a
// merge shifts only the entries after it down. busy stays high for one cycle
// after reset while entry 0 is loaded.
module variable_partition_allocator_core import vpa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  seg_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  seg_t          mem_rdata;

  vpa_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  vpa_mem #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
